>>> rtl/dbf_pkg.sv
// Shared types, register map and arithmetic helpers for the deblocking filter.
package dbf_pkg;

    localparam int PIX_W  = 8;
    localparam int LIM_W  = 10;
    localparam int CLS_W  = 2;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int NUM_CLS = 4;

    // register indexes
    localparam logic [2:0] REG_EDGE_LIMIT = 3'd0;
    localparam logic [2:0] REG_STR_CLS0   = 3'd1;
    localparam logic [2:0] REG_STR_CLS1   = 3'd2;
    localparam logic [2:0] REG_STR_CLS2   = 3'd3;
    localparam logic [2:0] REG_STR_CLS3   = 3'd4;

    localparam logic [CLS_W-1:0] CLS_INTRA = 2'd3;

    typedef logic [PIX_W-1:0]        t_pix;
    typedef logic [LIM_W-1:0]        t_lim;
    typedef logic [CLS_W-1:0]        t_cls;
    typedef logic [1:0]              t_dep;
    typedef logic [13:0]             t_act;
    typedef logic signed [14:0]      t_acc;
    typedef logic signed [9:0]       t_corr;
    typedef logic signed [10:0]      t_edge;

    // Word handed from the decision stages to the inner filter stages.
    typedef struct packed {
        t_pix  p0;
        t_pix  p1;
        t_pix  p2;
        t_pix  p5;
        t_pix  p6;
        t_pix  p7;
        t_edge new_le;
        t_edge new_re;
        t_dep  dep_l;
        t_dep  dep_r;
        t_pix  str_l;
        t_pix  str_r;
    } t_edge_word;

    function automatic t_acc px(input t_pix v);
        return t_acc'({7'd0, v});
    endfunction

    function automatic t_acc mag(input t_acc v);
        return (v < 0) ? -v : v;
    endfunction

    // Divide by 16, truncating toward zero.
    function automatic t_acc div16(input t_acc v);
        t_acc a;
        a = mag(v) >>> 4;
        return (v < 0) ? -a : a;
    endfunction

    // Four-pixel activity: |4(a-d) - 12(b-c)| + |9(a+d-b-c)|
    function automatic t_act activity(input t_pix a, input t_pix b,
                                      input t_pix c, input t_pix d);
        t_acc odd;
        t_acc even;
        t_acc sum;
        odd  = 15'sd4 * (px(a) - px(d)) - 15'sd12 * (px(b) - px(c));
        even = 15'sd9 * (px(a) + px(d) - px(b) - px(c));
        sum  = mag(odd) + mag(even);
        return sum[13:0];
    endfunction

endpackage

>>> rtl/dbf_cfg.sv
// APB register file: edge limit and the four class strengths.
module dbf_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dbf_pkg::ADDR_W-1:0] paddr,
    input  logic [dbf_pkg::DATA_W-1:0] pwdata,
    output logic [dbf_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dbf_pkg::t_lim              o_edge_limit,
    output dbf_pkg::t_pix              o_strength [dbf_pkg::NUM_CLS]
);
    import dbf_pkg::*;

    t_lim r_edge_limit;
    t_pix r_str [NUM_CLS];
    logic [2:0] idx;
    logic wr;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr    = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_limit <= '0;
            for (int k = 0; k < NUM_CLS; k++) r_str[k] <= '0;
        end else if (wr) begin
            case (idx)
                REG_EDGE_LIMIT: r_edge_limit <= pwdata[LIM_W-1:0];
                REG_STR_CLS0:   r_str[0] <= pwdata[PIX_W-1:0];
                REG_STR_CLS1:   r_str[1] <= pwdata[PIX_W-1:0];
                REG_STR_CLS2:   r_str[2] <= pwdata[PIX_W-1:0];
                REG_STR_CLS3:   r_str[3] <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_EDGE_LIMIT: prdata = DATA_W'(r_edge_limit);
            REG_STR_CLS0:   prdata = DATA_W'(r_str[0]);
            REG_STR_CLS1:   prdata = DATA_W'(r_str[1]);
            REG_STR_CLS2:   prdata = DATA_W'(r_str[2]);
            REG_STR_CLS3:   prdata = DATA_W'(r_str[3]);
            default:        prdata = '0;
        endcase
    end

    assign o_edge_limit = r_edge_limit;
    assign o_strength   = r_str;

endmodule

>>> rtl/dbf_analyze.sv
// Stages 1-2: activity measures, filter depths and the edge pair correction.
module dbf_analyze (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dbf_pkg::t_pix       i_pix [8],
    input  dbf_pkg::t_cls       i_cls_l,
    input  dbf_pkg::t_cls       i_cls_r,
    input  dbf_pkg::t_lim       i_edge_limit,
    input  dbf_pkg::t_pix       i_strength [dbf_pkg::NUM_CLS],
    output logic                o_valid,
    input  logic                i_ready,
    output dbf_pkg::t_edge_word o_word
);
    import dbf_pkg::*;

    // stage 1 registers
    logic        r_s1_vld;
    t_pix        r_s1_p [8];
    logic        r_s1_intra;
    t_act        r_s1_act_c;
    t_act        r_s1_act_l;
    t_act        r_s1_act_r;
    logic [12:0] r_s1_smooth_l;
    logic [12:0] r_s1_smooth_r;
    t_corr       r_s1_qa;
    t_corr       r_s1_qb;
    t_pix        r_s1_str_l;
    t_pix        r_s1_str_r;

    // stage 2 registers
    logic        r_s2_vld;
    t_edge_word  r_s2;

    logic s1_ready;
    logic s2_ready;

    t_acc sm_l, sm_r, num_a, num_b, qa, qb;

    always_comb begin
        sm_l  = t_acc'(12) * mag(px(i_pix[1]) + px(i_pix[3]) - 15'sd2 * px(i_pix[2]));
        sm_r  = t_acc'(12) * mag(px(i_pix[4]) + px(i_pix[6]) - 15'sd2 * px(i_pix[5]));
        num_a = 15'sd3 * (px(i_pix[2]) - px(i_pix[5]))
              - 15'sd8 * (px(i_pix[3]) - px(i_pix[4]));
        num_b = px(i_pix[1]) + px(i_pix[2]) - 15'sd8 * (px(i_pix[3]) - px(i_pix[4]))
              - px(i_pix[5]) - px(i_pix[6]);
        qa    = div16(num_a);
        qb    = div16(num_b);
    end

    assign s2_ready = !r_s2_vld || i_ready;
    assign s1_ready = !r_s1_vld || s2_ready;
    assign o_ready  = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_ready) begin
            r_s1_p        <= i_pix;
            r_s1_intra    <= (i_cls_l == CLS_INTRA) || (i_cls_r == CLS_INTRA);
            r_s1_act_c    <= activity(i_pix[2], i_pix[3], i_pix[4], i_pix[5]);
            r_s1_act_l    <= activity(i_pix[0], i_pix[1], i_pix[2], i_pix[3]);
            r_s1_act_r    <= activity(i_pix[4], i_pix[5], i_pix[6], i_pix[7]);
            r_s1_smooth_l <= sm_l[12:0];
            r_s1_smooth_r <= sm_r[12:0];
            r_s1_qa       <= qa[9:0];
            r_s1_qb       <= qb[9:0];
            r_s1_str_l    <= i_strength[i_cls_l];
            r_s1_str_r    <= i_strength[i_cls_r];
        end
    end

    // stage 2 decisions
    t_act        lim1, lim2, lim4;
    t_dep        joint, side_l, side_r, dep_l, dep_r, dep_lr;
    logic [9:0]  str_sum;
    t_edge       str_lr, corr_sel, corr;
    t_edge_word  n_s2;

    always_comb begin
        lim1 = t_act'(i_edge_limit);
        lim2 = t_act'({i_edge_limit, 1'b0});
        lim4 = t_act'({i_edge_limit, 2'b00});

        if (r_s1_act_c < lim1)      joint = 2'd3;
        else if (r_s1_act_c < lim2) joint = 2'd2;
        else if (r_s1_act_c < lim4) joint = 2'd1;
        else                        joint = {1'b0, r_s1_intra};

        side_l = 2'd1 + 2'(r_s1_smooth_l < 13'(i_edge_limit)) + 2'(r_s1_act_l < lim1);
        side_r = 2'd1 + 2'(r_s1_smooth_r < 13'(i_edge_limit)) + 2'(r_s1_act_r < lim1);

        dep_l  = (joint < side_l) ? joint : side_l;
        dep_r  = (joint < side_r) ? joint : side_r;
        dep_lr = 2'(({1'b0, dep_l} + {1'b0, dep_r}) >> 1);

        // sides are at least one each, so the sum never goes negative
        str_sum = 10'(r_s1_str_l) + 10'(r_s1_str_r) + 10'(side_l) + 10'(side_r) - 10'd2;
        str_lr  = t_edge'({2'b00, str_sum[9:1]});

        case (dep_lr)
            2'd1, 2'd2: corr_sel = t_edge'(r_s1_qa);
            2'd3:       corr_sel = t_edge'(r_s1_qb);
            default:    corr_sel = '0;
        endcase

        if (corr_sel > str_lr)       corr = str_lr;
        else if (corr_sel < -str_lr) corr = -str_lr;
        else                         corr = corr_sel;

        n_s2.p0     = r_s1_p[0];
        n_s2.p1     = r_s1_p[1];
        n_s2.p2     = r_s1_p[2];
        n_s2.p5     = r_s1_p[5];
        n_s2.p6     = r_s1_p[6];
        n_s2.p7     = r_s1_p[7];
        n_s2.new_le = t_edge'({3'b000, r_s1_p[3]}) + corr;
        n_s2.new_re = t_edge'({3'b000, r_s1_p[4]}) - corr;
        n_s2.dep_l  = dep_l;
        n_s2.dep_r  = dep_r;
        n_s2.str_l  = r_s1_str_l;
        n_s2.str_r  = r_s1_str_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_ready) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s2_ready) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_word  = r_s2;

`ifndef SYNTHESIS
    // a stalled word stays put
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && !i_ready |=> r_s2_vld && $stable(r_s2))
        else $error("stage 2 word changed under stall");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s2_ready |=> r_s1_vld && $stable(r_s1_act_c))
        else $error("stage 1 word lost under stall");

    // both side depths are zero together or not at all
    a_dep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> ((r_s2.dep_l == 2'd0) == (r_s2.dep_r == 2'd0)))
        else $error("side depths disagree on zero");
`endif

endmodule

>>> rtl/dbf_filter.sv
// Stages 3-4: inner pixel correction, clamping and output register.
module dbf_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dbf_pkg::t_edge_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output dbf_pkg::t_pix       o_left_near1,
    output dbf_pkg::t_pix       o_left_edge,
    output dbf_pkg::t_pix       o_right_edge,
    output dbf_pkg::t_pix       o_right_near1
);
    import dbf_pkg::*;

    logic  r_s3_vld;
    t_corr r_s3_corr_l;
    t_corr r_s3_corr_r;
    t_pix  r_s3_p2;
    t_pix  r_s3_p5;
    t_edge r_s3_le;
    t_edge r_s3_re;
    t_pix  r_s3_str_l;
    t_pix  r_s3_str_r;

    logic  r_s4_vld;
    t_pix  r_s4_ln;
    t_pix  r_s4_le;
    t_pix  r_s4_re;
    t_pix  r_s4_rn;

    logic s3_ready;
    logic s4_ready;

    assign s4_ready = !r_s4_vld || i_ready;
    assign s3_ready = !r_s3_vld || s4_ready;
    assign o_ready  = s3_ready;

    // stage 3: correction terms from the already corrected edge pair
    t_acc le, re, nl2, nl3, nr2, nr3, cl, cr;

    always_comb begin
        le  = t_acc'(i_word.new_le);
        re  = t_acc'(i_word.new_re);
        nl2 = 15'sd5 * (px(i_word.p1) - 15'sd2 * px(i_word.p2) + le);
        nl3 = 15'sd3 * (px(i_word.p0) + px(i_word.p1) - 15'sd4 * px(i_word.p2) + le + re);
        nr2 = 15'sd5 * (re - 15'sd2 * px(i_word.p5) + px(i_word.p6));
        nr3 = 15'sd3 * (le + re - 15'sd4 * px(i_word.p5) + px(i_word.p6) + px(i_word.p7));
        case (i_word.dep_l)
            2'd2:    cl = div16(nl2);
            2'd3:    cl = div16(nl3);
            default: cl = '0;
        endcase
        case (i_word.dep_r)
            2'd2:    cr = div16(nr2);
            2'd3:    cr = div16(nr3);
            default: cr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (s3_ready) begin
            r_s3_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s3_ready) begin
            r_s3_corr_l <= cl[9:0];
            r_s3_corr_r <= cr[9:0];
            r_s3_p2     <= i_word.p2;
            r_s3_p5     <= i_word.p5;
            r_s3_le     <= i_word.new_le;
            r_s3_re     <= i_word.new_re;
            r_s3_str_l  <= i_word.str_l;
            r_s3_str_r  <= i_word.str_r;
        end
    end

    // stage 4: clamp to side strength, add, saturate
    function automatic t_edge clamp_s(input t_corr v, input t_pix b);
        t_edge sv;
        t_edge sb;
        sv = t_edge'(v);
        sb = t_edge'({3'b000, b});
        if (sv > sb)  return sb;
        if (sv < -sb) return -sb;
        return sv;
    endfunction

    function automatic t_pix sat(input t_edge v);
        if (v < 0)               return '0;
        if (v > 11'sd255)        return 8'hFF;
        return v[7:0];
    endfunction

    t_edge ln, rn;

    always_comb begin
        ln = t_edge'({3'b000, r_s3_p2}) + clamp_s(r_s3_corr_l, r_s3_str_l);
        rn = t_edge'({3'b000, r_s3_p5}) + clamp_s(r_s3_corr_r, r_s3_str_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (s4_ready) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld && s4_ready) begin
            r_s4_ln <= sat(ln);
            r_s4_le <= sat(r_s3_le);
            r_s4_re <= sat(r_s3_re);
            r_s4_rn <= sat(rn);
        end
    end

    assign o_valid       = r_s4_vld;
    assign o_left_near1  = r_s4_ln;
    assign o_left_edge   = r_s4_le;
    assign o_right_edge  = r_s4_re;
    assign o_right_near1 = r_s4_rn;

endmodule

>>> rtl/block_edge_deblock_filter.sv
// Block edge deblocking filter, top level.
//
// Input channel: eight pixels across one block edge plus a strength class
// per side, on i_in_valid / o_in_ready. Output channel: the four filtered
// pixels nearest the edge, on o_out_valid / i_out_ready. A word moves when
// valid and ready are both high at a rising clock edge.
// Configuration: APB-style port, registers at byte addresses 0x00 (edge
// limit), 0x04..0x10 (strength of classes 0..3). Write them while idle.
// Pipeline: four register stages (activity, depth and edge pair, inner
// correction terms, clamp and saturate). An accepted word passes through
// them in that order to the output register; one word per cycle is taken
// and delivered in steady state while i_out_ready stays high.
// Stall: when i_out_ready is low the output word holds and the stages
// behind it fill up; o_in_ready drops only once every stage is occupied.
// Reset (i_rst_n low, synchronous): all stages empty, configuration registers cleared.
module block_edge_deblock_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  dbf_pkg::t_pix              i_left_far3,
    input  dbf_pkg::t_pix              i_left_far2,
    input  dbf_pkg::t_pix              i_left_near1,
    input  dbf_pkg::t_pix              i_left_edge,
    input  dbf_pkg::t_pix              i_right_edge,
    input  dbf_pkg::t_pix              i_right_near1,
    input  dbf_pkg::t_pix              i_right_far2,
    input  dbf_pkg::t_pix              i_right_far3,
    input  dbf_pkg::t_cls              i_left_class,
    input  dbf_pkg::t_cls              i_right_class,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output dbf_pkg::t_pix              o_out_left_near1,
    output dbf_pkg::t_pix              o_out_left_edge,
    output dbf_pkg::t_pix              o_out_right_edge,
    output dbf_pkg::t_pix              o_out_right_near1,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dbf_pkg::ADDR_W-1:0] paddr,
    input  logic [dbf_pkg::DATA_W-1:0] pwdata,
    output logic [dbf_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import dbf_pkg::*;

    t_lim       edge_limit;
    t_pix       strength [NUM_CLS];
    t_pix       pix [8];
    logic       mid_valid;
    logic       mid_ready;
    t_edge_word mid_word;

    assign pix[0] = i_left_far3;
    assign pix[1] = i_left_far2;
    assign pix[2] = i_left_near1;
    assign pix[3] = i_left_edge;
    assign pix[4] = i_right_edge;
    assign pix[5] = i_right_near1;
    assign pix[6] = i_right_far2;
    assign pix[7] = i_right_far3;

    dbf_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_edge_limit (edge_limit),
        .o_strength   (strength)
    );

    dbf_analyze u_analyze (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_pix        (pix),
        .i_cls_l      (i_left_class),
        .i_cls_r      (i_right_class),
        .i_edge_limit (edge_limit),
        .i_strength   (strength),
        .o_valid      (mid_valid),
        .i_ready      (mid_ready),
        .o_word       (mid_word)
    );

    dbf_filter u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mid_valid),
        .o_ready       (mid_ready),
        .i_word        (mid_word),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_left_near1  (o_out_left_near1),
        .o_left_edge   (o_out_left_edge),
        .o_right_edge  (o_out_right_edge),
        .o_right_near1 (o_out_right_near1)
    );

endmodule
